// ===== sv/base64_stream_codec_macros.svh =====
// Assertion macros shared by the base64 stream codec modules.
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define B64S_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("b64s assertion failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define B64S_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("b64s assertion failed");

`endif

// ===== sv/b64s_pkg.sv =====
// Package for the base64 stream codec: widths, codes, result bundle and alphabet functions.
`timescale 1ns / 1ps

package b64s_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_URL_ALPHABET = 2'd1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // All results caused by one input item, sent out one per beat
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last;
    logic            has_data;
    logic            eos;
    logic            bad;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } dec_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + 8'(v);
    end else if (v < 6'd52) begin
      r = 8'h47 + 8'(v);
    end else if (v < 6'd62) begin
      r = 8'(v) - 8'd4;
    end else if (v == 6'd62) begin
      r = url ? 8'h2D : 8'h2B;
    end else begin
      r = url ? 8'h5F : 8'h2F;
    end
    return r;
  endfunction

  // Alphabet character to 6-bit value; ok is low for a character outside the alphabet
  function automatic dec_t dec_char(input logic [7:0] c, input logic url);
    dec_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c + 8'd4);
    end else if (c == (url ? 8'h2D : 8'h2B)) begin
      r.val = 6'd62;
    end else if (c == (url ? 8'h5F : 8'h2F)) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/b64s_ifs.sv =====
// Channel interfaces of the base64 stream codec: input items, results, configuration writes.
`timescale 1ns / 1ps

interface b64s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_item;
  modport source (output valid, in_byte, final_item, input ready);
  modport sink (input valid, in_byte, final_item, output ready);
endinterface

interface b64s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_data;
  logic       end_of_stream;
  logic       bad_char;
  modport source (output valid, out_byte, has_data, end_of_stream, bad_char, input ready);
  modport sink (input valid, out_byte, has_data, end_of_stream, bad_char, output ready);
endinterface

interface b64s_cfg_if;
  import b64s_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/b64s_core.sv =====
// Codec core: configuration registers, stream state and per-beat result bundle.
`timescale 1ns / 1ps
`include "base64_stream_codec_macros.svh"

module b64s_core (
  input  logic             clk,
  input  logic             rst,
  b64s_in_if.sink          feed,
  b64s_cfg_if.sink         cfg,
  input  logic             ser_free,
  output logic             take,
  output b64s_pkg::bundle_t bundle_next
);
  import b64s_pkg::*;

  logic       decode_mode;
  logic       url_alphabet;
  logic [5:0] bit_buf;
  logic [1:0] half_cnt;     // pending bit count divided by two
  logic       error_seen;
  logic       stop_seen;

  logic [5:0] bit_buf_next;
  logic [1:0] half_cnt_next;
  logic       error_seen_next;
  logic       stop_seen_next;
  logic       cfg_fire;
  dec_t       dv;
  logic [7:0] b;
  logic       fin;

  assign cfg.ready  = 1'b1;
  assign cfg_fire   = cfg.valid & cfg.ready;
  assign feed.ready = ser_free;
  assign take       = feed.valid & ser_free;
  assign b          = feed.in_byte;
  assign fin        = feed.final_item;
  assign dv         = dec_char(b, url_alphabet);

  // Result bundle and next stream state for the beat on the input
  always_comb begin
    bit_buf_next     = bit_buf;
    half_cnt_next    = half_cnt;
    error_seen_next  = error_seen;
    stop_seen_next   = stop_seen;
    bundle_next      = '0;
    bundle_next.has_data = 1'b1;
    bundle_next.eos  = fin;
    if (!decode_mode) begin
      // encode: 0, 2 or 4 bits pending
      case (half_cnt)
        2'd0: begin
          bundle_next.chars[0] = enc_char(b[7:2], url_alphabet);
          bit_buf_next  = {4'd0, b[1:0]};
          half_cnt_next = 2'd1;
          if (fin) begin
            bundle_next.chars[1] = enc_char({b[1:0], 4'd0}, url_alphabet);
            bundle_next.chars[2] = PAD_CHAR;
            bundle_next.chars[3] = PAD_CHAR;
            bundle_next.last     = url_alphabet ? 2'd1 : 2'd3;
          end
        end
        2'd1: begin
          bundle_next.chars[0] = enc_char({bit_buf[1:0], b[7:4]}, url_alphabet);
          bit_buf_next  = {2'd0, b[3:0]};
          half_cnt_next = 2'd2;
          if (fin) begin
            bundle_next.chars[1] = enc_char({b[3:0], 2'd0}, url_alphabet);
            bundle_next.chars[2] = PAD_CHAR;
            bundle_next.last     = url_alphabet ? 2'd1 : 2'd2;
          end
        end
        default: begin
          bundle_next.chars[0] = enc_char({bit_buf[3:0], b[7:6]}, url_alphabet);
          bundle_next.chars[1] = enc_char(b[5:0], url_alphabet);
          bundle_next.last     = 2'd1;
          bit_buf_next  = 6'd0;
          half_cnt_next = 2'd0;
        end
      endcase
    end else begin
      // decode: always one result, 0, 2, 4 or 6 bits pending
      bundle_next.has_data = 1'b0;
      if (!error_seen && !stop_seen) begin
        if (b == PAD_CHAR) begin
          stop_seen_next = url_alphabet;
        end else if (!dv.ok) begin
          error_seen_next = 1'b1;
        end else begin
          case (half_cnt)
            2'd0: begin
              bit_buf_next  = dv.val;
              half_cnt_next = 2'd3;
            end
            2'd1: begin
              bundle_next.chars[0] = {bit_buf[1:0], dv.val};
              bundle_next.has_data = 1'b1;
              half_cnt_next        = 2'd0;
            end
            2'd2: begin
              bundle_next.chars[0] = {bit_buf[3:0], dv.val[5:2]};
              bundle_next.has_data = 1'b1;
              bit_buf_next         = {4'd0, dv.val[1:0]};
              half_cnt_next        = 2'd1;
            end
            default: begin
              bundle_next.chars[0] = {bit_buf, dv.val[5:4]};
              bundle_next.has_data = 1'b1;
              bit_buf_next         = {2'd0, dv.val[3:0]};
              half_cnt_next        = 2'd2;
            end
          endcase
        end
      end
      bundle_next.bad = error_seen_next;
    end
    // stream state clears after the final beat
    if (fin) begin
      bit_buf_next    = 6'd0;
      half_cnt_next   = 2'd0;
      error_seen_next = 1'b0;
      stop_seen_next  = 1'b0;
    end
  end

  // Configuration and stream state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= 1'b0;
      url_alphabet <= 1'b0;
      bit_buf      <= 6'd0;
      half_cnt     <= 2'd0;
      error_seen   <= 1'b0;
      stop_seen    <= 1'b0;
    end else if (cfg_fire) begin
      if (cfg.index == REG_DECODE_MODE) begin
        decode_mode <= cfg.data[0];
      end
      if (cfg.index == REG_URL_ALPHABET) begin
        url_alphabet <= cfg.data[0];
      end
      if (cfg.index == REG_DECODE_MODE || cfg.index == REG_URL_ALPHABET) begin
        bit_buf    <= 6'd0;
        half_cnt   <= 2'd0;
        error_seen <= 1'b0;
        stop_seen  <= 1'b0;
      end
    end else if (take) begin
      bit_buf    <= bit_buf_next;
      half_cnt   <= half_cnt_next;
      error_seen <= error_seen_next;
      stop_seen  <= stop_seen_next;
    end
  end

  `B64S_ASSERT_IMP(a_dec_one_result, take && decode_mode, bundle_next.last == 2'd0)
  `B64S_ASSERT_IMP(a_enc_never_bad, take && !decode_mode, !bundle_next.bad)
  `B64S_ASSERT_NXT(a_err_sticky, error_seen && !(take && fin) && !cfg_fire, error_seen)

endmodule

// ===== sv/b64s_ser.sv =====
// Result register: holds one item's bundle and sends its results one beat at a time.
`timescale 1ns / 1ps
`include "base64_stream_codec_macros.svh"

module b64s_ser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  b64s_pkg::bundle_t bundle_next,
  output logic             ser_free,
  b64s_out_if.source       result
);
  import b64s_pkg::*;

  logic       valid;
  logic [1:0] idx;
  bundle_t    bundle;
  logic       last_beat;
  logic       fire;

  assign last_beat = (idx == bundle.last);
  assign fire      = result.valid & result.ready;
  // free now, or freed by this beat leaving
  assign ser_free  = !valid || (result.ready && last_beat);

  assign result.valid         = valid;
  assign result.out_byte      = bundle.chars[idx];
  assign result.has_data      = bundle.has_data;
  assign result.end_of_stream = bundle.eos && last_beat;
  assign result.bad_char      = bundle.bad;

  // Control: occupancy and beat index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (take) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (fire) begin
      if (last_beat) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      bundle <= bundle_next;
    end
  end

  `B64S_ASSERT_IMP(a_idx_in_range, valid, idx <= bundle.last)
  `B64S_ASSERT_IMP(a_load_when_free, take, !valid || (fire && last_beat))
  `B64S_ASSERT_NXT(a_stall_holds_idx, valid && !result.ready, valid && $stable(idx))

endmodule

// ===== sv/base64_stream_codec.sv =====
// Base64 stream codec (standard or URL-safe alphabet): top level.
`timescale 1ns / 1ps

// Encodes bytes to Base64 characters or decodes characters to bytes, one item per input
// beat, chosen by the decode_mode and url_alphabet registers (a write to either clears
// the stream state). Results leave one per beat from a single result register: a decode
// item gives one result; an encode item gives one result, or two on every third byte,
// and up to four on the final byte (padding). The next item is taken in the same cycle
// the last result of the current one leaves, so with a ready consumer there are no idle
// cycles between items. On a decode error bad_char stays set for the rest of the stream
// and the stream should be discarded. No clearing pass after reset.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst,
  b64s_in_if.sink    feed,
  b64s_out_if.source result,
  b64s_cfg_if.sink   cfg
);
  import b64s_pkg::*;

  logic    take;
  logic    ser_free;
  bundle_t bundle_next;

  b64s_core u_core (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .cfg        (cfg),
    .ser_free   (ser_free),
    .take       (take),
    .bundle_next(bundle_next)
  );

  b64s_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .bundle_next(bundle_next),
    .ser_free   (ser_free),
    .result     (result)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the base64 stream codec: directed and random streams checked beat by beat.
`timescale 1ns / 1ps

module tb_top;
  import b64s_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_ITEMS = 500;

  // Unused register slots; writes there must leave everything as it is
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Symbols for values 62 and 63 in each alphabet
  localparam logic [7:0] SYM62_STD = 8'h2B;
  localparam logic [7:0] SYM63_STD = 8'h2F;
  localparam logic [7:0] SYM62_URL = 8'h2D;
  localparam logic [7:0] SYM63_URL = 8'h5F;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } feed_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       eos;
    logic       bad;
  } codec_beat_t;

  logic clk;
  logic rst;

  b64s_in_if  feed_ch ();
  b64s_out_if result_ch ();
  b64s_cfg_if cfg_ch ();

  base64_stream_codec dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  feed_item_t  pending_items[$];
  codec_beat_t expected_beats[$];

  // Handshakes seen at the last rising edge
  logic feed_acc;
  logic res_acc;
  logic cfg_acc;

  int feed_gap_max;
  int res_stall_max;
  int feed_wait;
  int res_wait;
  int fail_count;

  // Codec state as the predictor tracks it
  logic        dec_mode;
  logic        url_mode;
  logic [11:0] pend_bits;
  logic [3:0]  pend_count;
  logic [1:0]  char_count;
  logic        bad_seen;
  logic        pad_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // 6-bit group to alphabet symbol
  function automatic logic [7:0] alpha_char(input logic [5:0] v, input logic url);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return url ? SYM62_URL : SYM62_STD;
    return url ? SYM63_URL : SYM63_STD;
  endfunction

  // Symbol to 6-bit group; bit 6 set means not in the alphabet
  function automatic logic [6:0] alpha_value(input logic [7:0] c, input logic url);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
    if (c == (url ? SYM62_URL : SYM62_STD)) return 7'd62;
    if (c == (url ? SYM63_URL : SYM63_STD)) return 7'd63;
    return 7'd64;
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 12;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic stream_clear();
    pend_bits  = '0;
    pend_count = '0;
    char_count = '0;
    bad_seen   = 1'b0;
    pad_seen   = 1'b0;
  endtask

  // Works out the beats one accepted item causes
  task automatic predict_item(input logic [7:0] b, input logic fin);
    codec_beat_t beats[$];
    logic [11:0] acc;
    logic [6:0]  dv;
    logic [7:0]  ob;
    logic        oh;
    int          nb;
    if (dec_mode) begin
      ob = 8'd0;
      oh = 1'b0;
      if (!bad_seen && !pad_seen) begin
        if (b == PAD_CHAR) begin
          // padding: skipped in standard mode, ends the stream content in URL mode
          if (url_mode) pad_seen = 1'b1;
        end else begin
          dv = alpha_value(b, url_mode);
          if (dv[6]) begin
            bad_seen = 1'b1;
          end else begin
            nb  = (pend_count > 4'd6) ? 6 : int'(pend_count);
            acc = {pend_bits[5:0], dv[5:0]};
            nb += 6;
            if (nb >= 8) begin
              ob = 8'(acc >> (nb - 8));
              oh = 1'b1;
              nb -= 8;
            end
            pend_bits  = acc & ((12'd1 << nb) - 12'd1);
            pend_count = 4'(nb);
          end
        end
      end
      expected_beats.push_back('{ob, oh, fin, bad_seen});
      if (fin) stream_clear();
    end else begin
      nb  = (pend_count > 4'd4) ? 4 : int'(pend_count);
      acc = {pend_bits[3:0], b};
      nb += 8;
      while (nb >= 6 && beats.size() < 4) begin
        beats.push_back('{alpha_char(6'(acc >> (nb - 6)), url_mode), 1'b1, 1'b0, 1'b0});
        nb -= 6;
        char_count++;
      end
      acc &= (12'd1 << nb) - 12'd1;
      if (fin) begin
        // flush zero-filled leftover bits, then pad in standard mode
        if (nb > 0 && beats.size() < 4) begin
          beats.push_back('{alpha_char(6'(acc << (6 - nb)), url_mode), 1'b1, 1'b0, 1'b0});
          char_count++;
        end
        if (!url_mode) begin
          while (char_count != 2'd0 && beats.size() < 4) begin
            beats.push_back('{PAD_CHAR, 1'b1, 1'b0, 1'b0});
            char_count++;
          end
        end
        beats[beats.size() - 1].eos = 1'b1;
        stream_clear();
      end else begin
        pend_bits  = acc;
        pend_count = 4'(nb);
      end
      foreach (beats[i]) expected_beats.push_back(beats[i]);
    end
  endtask

  task automatic flag_beat(input string what, input codec_beat_t want, input codec_beat_t got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%s: expected byte %h data %b eos %b bad %b, got byte %h data %b eos %b bad %b",
               what, want.out_byte, want.has_data, want.eos, want.bad,
               got.out_byte, got.has_data, got.eos, got.bad);
  endtask

  // Monitor: predictor update, result check and watchdog at the rising edge
  always @(posedge clk) begin
    codec_beat_t got;
    codec_beat_t want;
    int          idle_cycles;
    if (rst) begin
      dec_mode = 1'b0;
      url_mode = 1'b0;
      stream_clear();
      feed_acc <= 1'b0;
      res_acc  <= 1'b0;
      cfg_acc  <= 1'b0;
      idle_cycles = 0;
    end else begin
      feed_acc <= feed_ch.valid && feed_ch.ready;
      res_acc  <= result_ch.valid && result_ch.ready;
      cfg_acc  <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_DECODE_MODE) begin
          dec_mode = cfg_ch.data[0];
          stream_clear();
        end else if (cfg_ch.index == REG_URL_ALPHABET) begin
          url_mode = cfg_ch.data[0];
          stream_clear();
        end
      end
      if (feed_ch.valid && feed_ch.ready)
        predict_item(feed_ch.in_byte, feed_ch.final_item);
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.out_byte, result_ch.has_data, result_ch.end_of_stream,
                result_ch.bad_char};
        if (expected_beats.size() == 0) begin
          flag_beat("unexpected beat", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) flag_beat("mismatch", want, got);
        end
      end
      if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Input driver: one item per beat, random gap after each
  always @(negedge clk) begin
    feed_item_t it;
    if (rst) begin
      feed_ch.valid <= 1'b0;
      feed_wait = 0;
    end else if (!feed_ch.valid || feed_acc) begin
      if (feed_wait > 0) begin
        feed_ch.valid <= 1'b0;
        feed_wait--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        feed_ch.valid      <= 1'b1;
        feed_ch.in_byte    <= it.data;
        feed_ch.final_item <= it.last;
        feed_wait = $urandom_range(0, feed_gap_max);
      end else begin
        feed_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall after each beat, now and then while waiting too
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      res_wait = 0;
    end else begin
      if (res_acc || (res_wait == 0 && $urandom_range(0, 15) == 0))
        res_wait = $urandom_range(0, res_stall_max);
      if (res_wait > 0) begin
        result_ch.ready <= 1'b0;
        res_wait--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic enqueue_item(input logic [7:0] b, input logic fin);
    pending_items.push_back('{b, fin});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_acc);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Idle means nothing queued, nothing offered and no beat still owed;
  // checked at the rising edge, where the driver never changes the queue
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || feed_ch.valid || expected_beats.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int         sent;
    int         len;
    int         pick;
    logic       dm;
    logic       um;
    logic [7:0] b;
    logic       fin;
    rst                = 1'b1;
    feed_ch.valid      = 1'b0;
    feed_ch.in_byte    = 8'd0;
    feed_ch.final_item = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    result_ch.ready    = 1'b0;
    feed_gap_max       = 0;
    res_stall_max      = 0;
    fail_count         = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Standard encode from reset values: one, two and three byte streams
    enqueue_item(8'h00, 1'b1);
    enqueue_item(8'hFF, 1'b0);
    enqueue_item(8'hFB, 1'b1);
    enqueue_item(8'hFB, 1'b0);
    enqueue_item(8'hEF, 1'b0);
    enqueue_item(8'hFF, 1'b1);
    wait_drained();

    // URL encode, no padding
    write_reg(REG_URL_ALPHABET, 1'b1);
    enqueue_item(8'hFB, 1'b1);
    enqueue_item(8'hFF, 1'b0);
    enqueue_item(8'hFE, 1'b1);
    wait_drained();

    // Standard decode: pad skipped, invalid character sticky, invalid on the final item
    write_reg(REG_DECODE_MODE, 1'b1);
    write_reg(REG_URL_ALPHABET, 1'b0);
    enqueue_item("z", 1'b0);
    enqueue_item("9", 1'b0);
    enqueue_item(SYM62_STD, 1'b0);
    enqueue_item(SYM63_STD, 1'b0);
    enqueue_item(PAD_CHAR, 1'b1);
    enqueue_item(8'h00, 1'b0);
    enqueue_item("A", 1'b1);
    enqueue_item(8'hFF, 1'b1);
    wait_drained();

    // URL decode: everything after the pad ignored, '+' invalid
    write_reg(REG_URL_ALPHABET, 1'b1);
    enqueue_item(SYM62_URL, 1'b0);
    enqueue_item(SYM63_URL, 1'b0);
    enqueue_item(PAD_CHAR, 1'b0);
    enqueue_item("A", 1'b1);
    enqueue_item(SYM62_STD, 1'b0);
    enqueue_item("Q", 1'b1);

    // Random phases, each with its own settings and pacing
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      dm = 1'($urandom_range(0, 1));
      um = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_DECODE_MODE, dm);
        write_reg(REG_URL_ALPHABET, um);
      end else begin
        write_reg(REG_URL_ALPHABET, um);
        write_reg(REG_DECODE_MODE, dm);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 1'($urandom_range(0, 1)));
      feed_gap_max  = pick_pace();
      res_stall_max = pick_pace();
      repeat ($urandom_range(4, 10)) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          // a stream is sometimes left open: it runs on or is cut by the next write
          fin = (i == len - 1) && ($urandom_range(0, 9) != 0);
          if (!dm) begin
            b = 8'($urandom_range(0, 255));
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 84)      b = alpha_char(6'($urandom_range(0, 63)), um);
            else if (pick < 90) b = PAD_CHAR;
            else                b = 8'($urandom_range(0, 255));
          end
          enqueue_item(b, fin);
          sent++;
        end
      end
    end
    wait_drained();

    if (fail_count == 0 && expected_beats.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
